[sv/gspd_pkg.sv]
// Shared types, constants and command tables for the gamepad serial poll decoder.
// No dependencies; imported by every module of the block.
package gspd_pkg;

   localparam int FRAME_BYTES_DEF = 9;
   localparam int FRAME_BYTES_MAX = 32;
   localparam int BYTE_IDX_W      = $clog2(FRAME_BYTES_MAX + 1);

   localparam logic [15:0] HALF_PERIOD_RST = 16'd8;

   // request codes carried in req_tuser
   localparam logic [1:0] REQ_NONE  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_SETUP = 2'd2;

   // mode byte values reported by the pad
   localparam logic [7:0] MODE_DIGITAL = 8'h41;
   localparam logic [7:0] MODE_ANALOG  = 8'h73;

   // command bytes
   localparam logic [7:0] CMD_START    = 8'h01;
   localparam logic [7:0] CMD_POLL     = 8'h42;
   localparam logic [7:0] CMD_CONFIG   = 8'h43;
   localparam logic [7:0] CMD_SET_MODE = 8'h44;
   localparam logic [7:0] ARG_ONE      = 8'h01;
   localparam logic [7:0] ARG_LOCK     = 8'h03;
   localparam logic [7:0] ARG_PAD      = 8'h5A;

   localparam logic [2:0] SETUP_FRAMES   = 3'd5;
   localparam logic [2:0] SETUP_LAST     = 3'd4;
   localparam logic [2:0] SETUP_ENTER    = 3'd1;
   localparam logic [2:0] SETUP_ANALOG   = 3'd2;
   localparam logic [3:0] SETUP_LEN_LONG = 4'd9;
   localparam logic [3:0] SETUP_LEN_SHRT = 4'd5;

   typedef struct packed {
      logic                  sck;
      logic                  mosi;
      logic                  ss_n;
   } pin_type;

   typedef struct packed {
      logic                  wr_en;
      logic [BYTE_IDX_W-1:0] wr_idx;
      logic [7:0]            wr_data;
      logic                  done;
   } frame_evt_type;

   typedef struct packed {
      logic                  frame_valid;
      logic                  analog_mode;
      logic [15:0]           buttons;
      logic [7:0]            right_x;
      logic [7:0]            right_y;
      logic [7:0]            left_x;
      logic [7:0]            left_y;
   } pad_status_type;

   function automatic logic [2:0] setup_clamp(input logic [2:0] frame);
      setup_clamp = (frame < SETUP_FRAMES) ? frame : SETUP_LAST;
   endfunction

   function automatic logic [3:0] setup_len(input logic [2:0] frame);
      logic [2:0] f;
      f = setup_clamp(frame);
      setup_len = (f == SETUP_ANALOG || f == SETUP_LAST) ? SETUP_LEN_LONG : SETUP_LEN_SHRT;
   endfunction

   // transmit byte of setup frame 'frame', byte 'idx' (idx below nine)
   function automatic logic [7:0] setup_tx_byte(input logic [2:0] frame,
                                                input logic [3:0] idx);
      logic [2:0] f;
      logic [7:0] b;
      f = setup_clamp(frame);
      b = 8'h00;
      if (idx == 4'd0) begin
         b = CMD_START;
      end else if (idx == 4'd1) begin
         if (f == SETUP_ENTER || f == SETUP_LAST) b = CMD_CONFIG;
         else if (f == SETUP_ANALOG)              b = CMD_SET_MODE;
         else                                     b = CMD_POLL;
      end else if (idx == 4'd3 && (f == SETUP_ENTER || f == SETUP_ANALOG)) begin
         b = ARG_ONE;
      end else if (idx == 4'd4 && f == SETUP_ANALOG) begin
         b = ARG_LOCK;
      end else if (idx >= 4'd4 && idx <= 4'd8 && f == SETUP_LAST) begin
         b = ARG_PAD;
      end
      setup_tx_byte = b;
   endfunction

endpackage

[sv/gspd_seq.sv]
// Link sequencer: frame/bit timing, pin levels, command bytes and receive shifter.
// Depends on gspd_pkg.
module gspd_seq #(
   parameter int FRAME_BYTES = gspd_pkg::FRAME_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic                    tick_en,
   input  logic                    miso_level,
   input  logic [1:0]              req_type,
   input  logic [15:0]             half_period,
   output gspd_pkg::pin_type       pins_in,
   output logic                    busy_in,
   output gspd_pkg::frame_evt_type evt
);
   import gspd_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE, PH_SEL_GAP, PH_BIT_HIGH, PH_BIT_LOW, PH_BYTE_GAP, PH_END_GAP
   } phase_type;

   localparam logic [BYTE_IDX_W-1:0] LAST_BYTE_CAP = BYTE_IDX_W'(FRAME_BYTES);

   phase_type             phase_ff, phase_in;
   logic                  in_setup_ff, in_setup_in;
   logic [2:0]            sfi_ff, sfi_in;
   logic [BYTE_IDX_W-1:0] byte_ff, byte_in;
   logic [2:0]            bit_ff, bit_in;
   logic [15:0]           tick_ff, tick_in;
   logic [7:0]            rx_ff, rx_in;
   pin_type               pins_ff;

   logic [16:0]           tick_sum;
   logic [15:0]           limit;
   logic                  wrap;
   logic [7:0]            rx_bit;
   logic [BYTE_IDX_W-1:0] frame_len;
   logic [2:0]            sfi_inc;
   logic                  start;
   logic                  drive;
   logic [7:0]            tx_byte;

   assign limit     = (half_period == 16'd0) ? 16'd1 : half_period;
   assign tick_sum  = {1'b0, tick_ff} + 17'd1;
   assign wrap      = tick_sum >= {1'b0, limit};
   assign rx_bit    = rx_ff | (8'(miso_level) << bit_ff);
   assign sfi_inc   = sfi_ff + 3'd1;
   assign frame_len = in_setup_ff ? BYTE_IDX_W'(setup_len(sfi_ff)) : LAST_BYTE_CAP;

   always_comb begin
      phase_in    = phase_ff;
      in_setup_in = in_setup_ff;
      sfi_in      = sfi_ff;
      byte_in     = byte_ff;
      bit_in      = bit_ff;
      tick_in     = tick_ff;
      rx_in       = rx_ff;
      pins_in     = pins_ff;
      evt         = '0;
      start       = 1'b0;
      drive       = 1'b0;
      tx_byte     = 8'h00;

      if (phase_ff == PH_IDLE) begin
         if (req_type == REQ_READ || req_type == REQ_SETUP) begin
            in_setup_in = (req_type == REQ_SETUP);
            if (req_type == REQ_SETUP) sfi_in = 3'd0;
            start = 1'b1;
         end
      end else if (tick_en) begin
         if (!wrap) begin
            tick_in = tick_sum[15:0];
         end else begin
            tick_in = 16'd0;
            unique case (phase_ff)
               PH_SEL_GAP: begin
                  drive = 1'b1;
               end
               PH_BIT_HIGH: begin
                  pins_in.sck = 1'b0;
                  phase_in    = PH_BIT_LOW;
               end
               PH_BIT_LOW: begin
                  pins_in.sck = 1'b1;
                  if (bit_ff == 3'd7) begin
                     evt.wr_en   = !in_setup_ff && (byte_ff < LAST_BYTE_CAP);
                     evt.wr_idx  = byte_ff;
                     evt.wr_data = rx_bit;
                     rx_in       = 8'h00;
                     bit_in      = 3'd0;
                     phase_in    = PH_BYTE_GAP;
                  end else begin
                     rx_in  = rx_bit;
                     bit_in = bit_ff + 3'd1;
                     drive  = 1'b1;
                  end
               end
               PH_BYTE_GAP: begin
                  byte_in = byte_ff + BYTE_IDX_W'(1);
                  if (byte_in < frame_len) begin
                     drive = 1'b1;
                  end else begin
                     pins_in.ss_n = 1'b1;
                     phase_in     = PH_END_GAP;
                  end
               end
               PH_END_GAP: begin
                  if (in_setup_ff) begin
                     if (sfi_inc < SETUP_FRAMES) begin
                        sfi_in = sfi_inc;
                        start  = 1'b1;
                     end else begin
                        sfi_in      = 3'd0;
                        in_setup_in = 1'b0;
                        phase_in    = PH_IDLE;
                     end
                  end else begin
                     evt.done = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
               PH_IDLE: begin
                  phase_in = PH_IDLE;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end

      if (start) begin
         pins_in.ss_n = 1'b0;
         byte_in      = '0;
         bit_in       = 3'd0;
         rx_in        = 8'h00;
         tick_in      = 16'd0;
         phase_in     = PH_SEL_GAP;
      end

      // command byte for the bit about to go out
      if (in_setup_ff) begin
         if (byte_in < BYTE_IDX_W'(9)) tx_byte = setup_tx_byte(sfi_ff, byte_in[3:0]);
      end else if (byte_in == BYTE_IDX_W'(0)) begin
         tx_byte = CMD_START;
      end else if (byte_in == BYTE_IDX_W'(1)) begin
         tx_byte = CMD_POLL;
      end

      if (drive) begin
         pins_in.sck  = 1'b1;
         pins_in.mosi = tx_byte[bit_in];
         phase_in     = PH_BIT_HIGH;
      end

      busy_in = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         in_setup_ff <= 1'b0;
         sfi_ff      <= 3'd0;
         byte_ff     <= '0;
         bit_ff      <= 3'd0;
         tick_ff     <= 16'd0;
         rx_ff       <= 8'h00;
         pins_ff     <= '1;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         in_setup_ff <= in_setup_in;
         sfi_ff      <= sfi_in;
         byte_ff     <= byte_in;
         bit_ff      <= bit_in;
         tick_ff     <= tick_in;
         rx_ff       <= rx_in;
         pins_ff     <= pins_in;
      end
   end

   // idle link: select deasserted and clock parked high
   a_idle_pins: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> pins_ff.ss_n && pins_ff.sck)
      else $error("pins not parked while idle");

   // bit counter only moves inside a byte
   a_bit_in_byte: assert property (@(posedge clock) disable iff (reset)
      bit_ff != 3'd0 |-> (phase_ff == PH_BIT_HIGH || phase_ff == PH_BIT_LOW))
      else $error("bit index left nonzero outside a byte");

   // a parse strobe never comes from a setup frame
   a_done_read_only: assert property (@(posedge clock) disable iff (reset)
      evt.done |-> !in_setup_ff && phase_ff == PH_END_GAP)
      else $error("frame done outside a read frame end");

   a_byte_bound: assert property (@(posedge clock) disable iff (reset)
      byte_ff <= LAST_BYTE_CAP)
      else $error("byte index ran past frame length");

endmodule

[sv/gspd_parse.sv]
// Receive byte store and frame parser: mode check, button inversion, stick capture.
// Depends on gspd_pkg; fed by gspd_seq.
module gspd_parse #(
   parameter int FRAME_BYTES = gspd_pkg::FRAME_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  gspd_pkg::frame_evt_type  evt,
   output gspd_pkg::pad_status_type status_in
);
   import gspd_pkg::*;

   logic [7:0]     frame_bytes_ff [FRAME_BYTES];
   pad_status_type status_ff;
   logic [7:0]     mode;

   // only entries written in the current frame are read at parse time
   always_ff @(posedge clock) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
         if (step_en && evt.wr_en && evt.wr_idx == BYTE_IDX_W'(i)) begin
            frame_bytes_ff[i] <= evt.wr_data;
         end
      end
   end

   assign mode = frame_bytes_ff[1];

   always_comb begin
      status_in = status_ff;
      if (evt.done) begin
         if (mode != MODE_DIGITAL && mode != MODE_ANALOG) begin
            status_in.frame_valid = 1'b0;
         end else begin
            status_in.frame_valid = 1'b1;
            status_in.buttons     = ~{frame_bytes_ff[4], frame_bytes_ff[3]};
            status_in.analog_mode = (mode == MODE_ANALOG);
            if (mode == MODE_ANALOG) begin
               status_in.right_x = frame_bytes_ff[5];
               status_in.right_y = frame_bytes_ff[6];
               status_in.left_x  = frame_bytes_ff[7];
               status_in.left_y  = frame_bytes_ff[8];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= '0;
      end else if (step_en) begin
         status_ff <= status_in;
      end
   end

endmodule

[sv/gamepad_serial_poll_decoder.sv]
// Top level of the gamepad serial poll decoder: input register, sequencer, parser,
// result register and half-period CSR. Depends on gspd_pkg, gspd_seq, gspd_parse.
//
// Master side of a PS2-style gamepad link. Each req item is one link cycle: a tick
// strobe, the sampled data-in pin and a request (read frame or five-frame setup
// sequence); requests are dropped while busy. Each item yields exactly one rsp item
// carrying the pin levels and decoded pad state after that cycle. Throughput is one
// item per clock while rsp is ready: the item is captured in an input register, the
// sequencer and parser step once when the result slot is free and the result lands in
// the output register, which drives rsp_tvalid. The path between the registers is one
// 16-bit tick add/compare plus the step selection. Backpressure on rsp holds the
// pipeline; one item can wait in each register. half_period_ticks is written via the
// csr channel (always ready) and should only be written with no item in flight; a
// value lowered mid-phase ends that phase on the next tick.
module gamepad_serial_poll_decoder #(
   parameter int FRAME_BYTES = gspd_pkg::FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [0] tick_en, [1] miso_level, [7:2] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // req_tuser: [1:0] req_type
   input  logic [1:0]  req_tuser,
   // rsp_tdata: [0] sck, [1] mosi, [2] ss_n, [3] busy_res, [4] frame_done,
   //   [5] frame_valid, [6] analog_mode, [22:7] buttons, [30:23] right_x,
   //   [38:31] right_y, [46:39] left_x, [54:47] left_y, [55] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   // csr_data: half_period_ticks
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import gspd_pkg::*;

   // input register
   logic        in_valid_ff;
   logic        in_tick_ff;
   logic        in_miso_ff;
   logic [1:0]  in_req_ff;

   // result register
   logic        out_valid_ff;
   logic [55:0] out_data_ff;
   logic [55:0] out_data_in;

   logic [15:0] half_period_ff;

   logic           step_en;
   pin_type        pins_in;
   logic           busy_in;
   frame_evt_type  evt;
   pad_status_type status_in;

   // step when an item is waiting and the result slot is free or draining
   assign step_en    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_en;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RST;
      end else if (csr_valid) begin
         half_period_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_tick_ff <= req_tdata[0];
         in_miso_ff <= req_tdata[1];
         in_req_ff  <= req_tuser;
      end
   end

   gspd_seq #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .tick_en     (in_tick_ff),
      .miso_level  (in_miso_ff),
      .req_type    (in_req_ff),
      .half_period (half_period_ff),
      .pins_in     (pins_in),
      .busy_in     (busy_in),
      .evt         (evt)
   );

   gspd_parse #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .evt       (evt),
      .status_in (status_in)
   );

   assign out_data_in = {1'b0,
                         status_in.left_y, status_in.left_x,
                         status_in.right_y, status_in.right_x,
                         status_in.buttons,
                         status_in.analog_mode, status_in.frame_valid,
                         evt.done, busy_in,
                         pins_in.ss_n, pins_in.mosi, pins_in.sck};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_en) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         out_data_ff <= out_data_in;
      end
   end

   // every stepped item shows up in the result register next cycle
   a_step_to_rsp: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_tvalid)
      else $error("stepped item did not reach the result register");

   // a frame done pulse in the result always carries an idle link
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff[4] |-> !out_data_ff[3] && out_data_ff[2])
      else $error("frame done reported while busy");

endmodule

[tb/sv/tb_gamepad_serial_poll_decoder.sv]
`timescale 1ns / 1ps
// Self-checking testbench for gamepad_serial_poll_decoder: drives link-cycle items and
// checks every response item against a cycle-exact predictor of the poll sequencer.
// Depends on gspd_pkg and the gamepad_serial_poll_decoder RTL.
module tb_gamepad_serial_poll_decoder;
   import gspd_pkg::*;

   localparam int          CYCLE_LIMIT   = 3_000_000;
   localparam int          SETTLE_CYCLES = 6;     // pause before a half-period write
   localparam int          TAIL_CYCLES   = 20;    // margin for the pipeline to drain
   localparam int          MAX_REPORTS   = 40;
   localparam logic [1:0]  REQ_RESERVED  = 2'd3;  // unused code, must act like no request

   // transmit bytes of the five setup frames: poll, enter config, analog lock,
   // poll, exit config
   localparam logic [7:0] SETUP_CMDS [5][9] = '{
      '{CMD_START, CMD_POLL,     8'h00, 8'h00,   8'h00,    8'h00,   8'h00,   8'h00,   8'h00},
      '{CMD_START, CMD_CONFIG,   8'h00, ARG_ONE, 8'h00,    8'h00,   8'h00,   8'h00,   8'h00},
      '{CMD_START, CMD_SET_MODE, 8'h00, ARG_ONE, ARG_LOCK, 8'h00,   8'h00,   8'h00,   8'h00},
      '{CMD_START, CMD_POLL,     8'h00, 8'h00,   8'h00,    8'h00,   8'h00,   8'h00,   8'h00},
      '{CMD_START, CMD_CONFIG,   8'h00, 8'h00,   ARG_PAD,  ARG_PAD, ARG_PAD, ARG_PAD, ARG_PAD}
   };
   localparam int SETUP_LEN [5] = '{5, 5, 9, 5, 9};

   typedef enum logic [2:0] {
      LINK_IDLE, LINK_SEL_GAP, LINK_BIT_HIGH, LINK_BIT_LOW, LINK_BYTE_GAP, LINK_END_GAP
   } link_phase_type;

   // one link cycle as sent on req
   typedef struct packed {
      logic       tick;
      logic       miso;
      logic [1:0] req;
   } link_item_type;

   // one response item, laid out as rsp_tdata[54:0] (sck at bit 0)
   typedef struct packed {
      logic [7:0]  left_y;
      logic [7:0]  left_x;
      logic [7:0]  right_y;
      logic [7:0]  right_x;
      logic [15:0] buttons;
      logic        analog_mode;
      logic        frame_valid;
      logic        frame_done;
      logic        busy;
      logic        ss_n;
      logic        mosi;
      logic        sck;
   } pad_sample_type;

   // reply bytes of one frame, byte 0 first
   typedef logic [0:8][7:0] reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic [1:0]  req_tuser = REQ_NONE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = 16'h0000;

   gamepad_serial_poll_decoder #(.FRAME_BYTES(FRAME_BYTES_DEF)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   link_item_type  link_items [$];        // items waiting for the driver
   pad_sample_type pad_samples_due [$];   // predicted responses, oldest first
   int          error_count = 0;
   int          cycle_count = 0;
   int          work_items  = 0;       // items that belong to frames
   int          gen_half    = int'(HALF_PERIOD_RST);  // effective ticks per half period
   int          src_gap = 0, src_steady = 0;
   int          sink_gap = 0, sink_steady = 0;

   // predictor state of the link sequencer
   link_phase_type link_phase;
   int          setup_frame;
   int          byte_cnt;
   logic [2:0]  bit_cnt;
   int          tick_cnt;
   logic [7:0]  rx_byte;
   reply_type   rx_bytes;
   logic        in_setup;
   logic        pin_sck, pin_mosi, pin_ss_n;
   logic [15:0] pad_buttons;
   logic [7:0]  pad_sticks [4];
   logic        pad_valid, pad_analog;
   logic [15:0] half_period;

   // ---------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------

   // select goes low and the frame starts with the select gap
   function automatic void open_frame();
      pin_ss_n   = 1'b0;
      byte_cnt   = 0;
      bit_cnt    = 3'd0;
      rx_byte    = 8'h00;
      tick_cnt   = 0;
      link_phase = LINK_SEL_GAP;
   endfunction

   // sck high, mosi to the current command bit
   function automatic void launch_bit();
      logic [7:0] tx;
      if (in_setup) tx = (byte_cnt < 9) ? SETUP_CMDS[setup_frame][byte_cnt] : 8'h00;
      else if (byte_cnt == 0) tx = CMD_START;
      else if (byte_cnt == 1) tx = CMD_POLL;
      else tx = 8'h00;
      pin_sck    = 1'b1;
      pin_mosi   = tx[bit_cnt];
      link_phase = LINK_BIT_HIGH;
   endfunction

   // advance the sequencer by one link cycle and return the pins and pad state after it
   function automatic pad_sample_type step_gamepad_link(input logic tick, input logic miso,
                                                        input logic [1:0] req);
      int             lim;
      logic           done;
      pad_sample_type s;
      lim  = (half_period == 16'd0) ? 1 : int'(half_period);
      done = 1'b0;
      if (link_phase == LINK_IDLE) begin
         // a request starts at once; this cycle's tick is not counted
         if (req == REQ_READ) begin
            in_setup = 1'b0;
            open_frame();
         end else if (req == REQ_SETUP) begin
            in_setup    = 1'b1;
            setup_frame = 0;
            open_frame();
         end
      end else if (tick) begin
         if (tick_cnt + 1 < lim) begin
            tick_cnt = tick_cnt + 1;
         end else begin
            tick_cnt = 0;
            case (link_phase)
               LINK_SEL_GAP: launch_bit();
               LINK_BIT_HIGH: begin
                  pin_sck    = 1'b0;
                  link_phase = LINK_BIT_LOW;
               end
               LINK_BIT_LOW: begin
                  // rising sck samples miso, LSB first
                  pin_sck = 1'b1;
                  if (miso) rx_byte[bit_cnt] = 1'b1;
                  if (bit_cnt == 3'd7) begin
                     if (!in_setup && byte_cnt < FRAME_BYTES_DEF) rx_bytes[byte_cnt] = rx_byte;
                     rx_byte    = 8'h00;
                     bit_cnt    = 3'd0;
                     link_phase = LINK_BYTE_GAP;
                  end else begin
                     bit_cnt = bit_cnt + 3'd1;
                     launch_bit();
                  end
               end
               LINK_BYTE_GAP: begin
                  byte_cnt = byte_cnt + 1;
                  if (byte_cnt < (in_setup ? SETUP_LEN[setup_frame] : FRAME_BYTES_DEF)) begin
                     launch_bit();
                  end else begin
                     pin_ss_n   = 1'b1;
                     link_phase = LINK_END_GAP;
                  end
               end
               LINK_END_GAP: begin
                  if (in_setup) begin
                     setup_frame = setup_frame + 1;
                     if (setup_frame < 5) begin
                        open_frame();
                     end else begin
                        setup_frame = 0;
                        in_setup    = 1'b0;
                        link_phase  = LINK_IDLE;
                     end
                  end else begin
                     // parse: unknown mode clears valid only, the rest is kept
                     if (rx_bytes[1] == MODE_DIGITAL || rx_bytes[1] == MODE_ANALOG) begin
                        pad_buttons = ~{rx_bytes[4], rx_bytes[3]};
                        pad_valid   = 1'b1;
                        pad_analog  = (rx_bytes[1] == MODE_ANALOG);
                        if (rx_bytes[1] == MODE_ANALOG) begin
                           pad_sticks[0] = rx_bytes[5];
                           pad_sticks[1] = rx_bytes[6];
                           pad_sticks[2] = rx_bytes[7];
                           pad_sticks[3] = rx_bytes[8];
                        end
                     end else begin
                        pad_valid = 1'b0;
                     end
                     done       = 1'b1;
                     link_phase = LINK_IDLE;
                  end
               end
               default: link_phase = LINK_IDLE;
            endcase
         end
      end
      s.sck         = pin_sck;
      s.mosi        = pin_mosi;
      s.ss_n        = pin_ss_n;
      s.busy        = (link_phase != LINK_IDLE);
      s.frame_done  = done;
      s.frame_valid = pad_valid;
      s.analog_mode = pad_analog;
      s.buttons     = pad_buttons;
      s.right_x     = pad_sticks[0];
      s.right_y     = pad_sticks[1];
      s.left_x      = pad_sticks[2];
      s.left_y      = pad_sticks[3];
      return s;
   endfunction

   // ---------------------------------------------------------------------------------
   // Idle-gap shaping: mostly short gaps, a few long ones, and stretches with none
   // ---------------------------------------------------------------------------------
   function automatic int draw_gap(inout int steady);
      int r;
      if (steady > 0) begin
         steady = steady - 1;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         steady = $urandom_range(30, 150);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   // ---------------------------------------------------------------------------------
   // Driver: one item per handshake; the accepted item is run through the predictor
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      link_item_type next_item;
      if (reset) begin
         req_tvalid    <= 1'b0;
         src_gap       = 0;
         link_phase    = LINK_IDLE;
         setup_frame   = 0;
         byte_cnt      = 0;
         bit_cnt       = 3'd0;
         tick_cnt      = 0;
         rx_byte       = 8'h00;
         rx_bytes      = '0;
         in_setup      = 1'b0;
         pin_sck       = 1'b1;
         pin_mosi      = 1'b1;
         pin_ss_n      = 1'b1;
         pad_buttons   = 16'h0000;
         pad_sticks    = '{default: 8'h00};
         pad_valid     = 1'b0;
         pad_analog    = 1'b0;
         half_period   = HALF_PERIOD_RST;
      end else begin
         if (req_tvalid && req_tready)
            pad_samples_due.push_back(step_gamepad_link(req_tdata[0], req_tdata[1], req_tuser));
         if (!req_tvalid || req_tready) begin
            if (src_gap > 0) begin
               src_gap    = src_gap - 1;
               req_tvalid <= 1'b0;
            end else if (link_items.size() > 0) begin
               next_item  = link_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {6'b0, next_item.miso, next_item.tick};
               req_tuser  <= next_item.req;
               src_gap    = draw_gap(src_steady);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Monitor: compare each response item with the oldest prediction, field by field
   // ---------------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      error_count = error_count + 1;
      if (error_count <= MAX_REPORTS)
         $display("%0t mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
   endtask

   task automatic match_field(input string what, input int unsigned got,
                              input int unsigned want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      pad_sample_type seen, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_gap   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = pad_sample_type'(rsp_tdata[54:0]);
            if (pad_samples_due.size() == 0) begin
               report_mismatch("response item with nothing predicted", rsp_tdata[31:0], 0);
            end else begin
               want = pad_samples_due.pop_front();
               match_field("sck",         seen.sck,         want.sck);
               match_field("mosi",        seen.mosi,        want.mosi);
               match_field("ss_n",        seen.ss_n,        want.ss_n);
               match_field("busy",        seen.busy,        want.busy);
               match_field("frame_done",  seen.frame_done,  want.frame_done);
               match_field("frame_valid", seen.frame_valid, want.frame_valid);
               match_field("analog_mode", seen.analog_mode, want.analog_mode);
               match_field("buttons",     seen.buttons,     want.buttons);
               match_field("right_x",     seen.right_x,     want.right_x);
               match_field("right_y",     seen.right_y,     want.right_y);
               match_field("left_x",      seen.left_x,      want.left_x);
               match_field("left_y",      seen.left_y,      want.left_y);
            end
            sink_gap = draw_gap(sink_steady);
         end
         if (sink_gap > 0) begin
            sink_gap   = sink_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus generation. The generator mirrors the frame timing so that the tick
   // completing each low half period carries the reply bit wanted for that position;
   // all other items get random miso. Requests during a frame must be dropped.
   // ---------------------------------------------------------------------------------
   task automatic push_item(input logic tick, input logic miso, input logic [1:0] req);
      link_item_type it;
      it.tick = tick;
      it.miso = miso;
      it.req  = req;
      link_items.push_back(it);
   endtask

   // 'count' ticks with random tickless items between; sample_bit < 0 means don't care
   task automatic push_ticks(input int count, input int sample_bit);
      int k, g;
      logic [1:0] busy_req;
      for (k = 0; k < count; k++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3: g = $urandom_range(1, 2);
            4:          g = $urandom_range(3, 10);
            default:    g = 0;
         endcase
         repeat (g) begin
            busy_req = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(0, 3)) : REQ_NONE;
            push_item(1'b0, 1'($urandom_range(0, 1)), busy_req);
         end
         busy_req = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(0, 3)) : REQ_NONE;
         if (k == count - 1 && sample_bit >= 0)
            push_item(1'b1, sample_bit[0], busy_req);
         else
            push_item(1'b1, 1'($urandom_range(0, 1)), busy_req);
         work_items = work_items + g + 1;
      end
   endtask

   // one half period or gap; the half period is rewritten first when its turn comes
   task automatic push_phase(inout int phase_no, input int switch_at,
                             input logic [15:0] switch_to, input int sample_bit);
      if (phase_no == switch_at) write_half_period(switch_to);
      push_ticks(gen_half, sample_bit);
      phase_no = phase_no + 1;
   endtask

   // select gap, 'len' bytes of eight bits plus byte gap each, then end gap;
   // a switch_at below zero keeps the half period for the whole frame
   task automatic push_frame(input reply_type reply, input int len, input int switch_at,
                             input logic [15:0] switch_to);
      int b, i, p;
      p = 0;
      push_phase(p, switch_at, switch_to, -1);
      for (b = 0; b < len; b++) begin
         for (i = 0; i < 8; i++) begin
            push_phase(p, switch_at, switch_to, -1);
            push_phase(p, switch_at, switch_to, int'(reply[b][i]));
         end
         push_phase(p, switch_at, switch_to, -1);
      end
      push_phase(p, switch_at, switch_to, -1);
   endtask

   task automatic queue_read_switch(input reply_type reply, input int switch_at,
                                    input logic [15:0] switch_to);
      push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), REQ_READ);
      work_items = work_items + 1;
      push_frame(reply, FRAME_BYTES_DEF, switch_at, switch_to);
   endtask

   task automatic queue_read(input reply_type reply);
      queue_read_switch(reply, -1, 16'd0);
   endtask

   task automatic queue_setup();
      int f;
      push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), REQ_SETUP);
      work_items = work_items + 1;
      for (f = 0; f < 5; f++) push_frame(random_reply(), SETUP_LEN[f], -1, 16'd0);
   endtask

   // items the idle block must ignore: no request or the reserved code
   task automatic push_noise(input int n);
      repeat (n)
         push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 1) ? REQ_RESERVED : REQ_NONE);
   endtask

   // mostly the two known modes, sometimes a random mode byte
   function automatic reply_type random_reply();
      reply_type r;
      int k;
      for (k = 0; k < 9; k++) r[k] = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 4))
         0, 1:    r[1] = MODE_ANALOG;
         2, 3:    r[1] = MODE_DIGITAL;
         default: ;
      endcase
      return r;
   endfunction

   task automatic wait_drained();
      while (link_items.size() != 0 || req_tvalid || pad_samples_due.size() != 0)
         @(posedge clock);
   endtask

   // half-period writes only happen with nothing in flight
   task automatic write_half_period(input logic [15:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      half_period = value;
      gen_half    = (value == 16'd0) ? 1 : int'(value);
   endtask

   task automatic random_phase(input int budget);
      int start;
      start = work_items;
      while (work_items - start < budget) begin
         if ($urandom_range(0, 9) == 0) queue_setup();
         else queue_read(random_reply());
         if ($urandom_range(0, 3) == 0) push_noise($urandom_range(1, 6));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // idle block: no request, reserved code, with and without ticks
      push_item(1'b0, 1'b0, REQ_NONE);
      push_item(1'b1, 1'b1, REQ_RESERVED);
      push_item(1'b1, 1'b0, REQ_NONE);
      push_item(1'b0, 1'b1, REQ_RESERVED);
      // reset half period for the select gap and the first two bits, then one tick:
      // analog frame, every button pressed, stick extremes
      queue_read_switch('{8'hFF, MODE_ANALOG, 8'h5A, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h7F},
                        5, 16'd1);
      // digital mode, nothing pressed; sticks must hold
      queue_read('{8'hFF, MODE_DIGITAL, 8'h5A, 8'hFF, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78});
      // setup sequence, then a read right behind it
      queue_setup();
      queue_read(random_reply());

      // zero half period behaves as one tick; unknown mode byte: only frame_valid drops
      write_half_period(16'd0);
      queue_read('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});

      // largest half period: idle traffic only
      write_half_period(16'hFFFF);
      push_noise(40);

      write_half_period(16'd1);
      random_phase(200);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_gamepad_serial_poll_decoder: clean");
      else
         $display("tb_gamepad_serial_poll_decoder: errors");
      $finish;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count = cycle_count + 1;
      end
      $display("tb_gamepad_serial_poll_decoder: errors");
      $finish;
   end

endmodule
